### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the battery level classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/blc_pkg.sv
// Package with widths, codes, register defaults and shared types of the classifier.
`default_nettype none
package blc_pkg;

  localparam int PIN_W     = 12;
  localparam int OHM_W     = 24;
  localparam int MV_W      = 16;
  localparam int PCT_W     = 7;
  localparam int CLASS_W   = 2;
  localparam int STATUS_W  = 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  // Numerator pin * (top + bottom) and the padded quotient of the divider.
  localparam int NUM_W       = PIN_W + OHM_W + 1;
  localparam int STEP_BITS   = 3;
  localparam int QUO_W       = ((NUM_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  // Percent stage: (v - empty) * 100 fits 23 bits, its quotient stays below 2^9.
  localparam int PROD_W      = MV_W + PCT_W;
  localparam int PCT_QUO_W   = 9;

  localparam logic [PCT_W-1:0] PERCENT_FULL = 7'd100;

  localparam logic [CLASS_W-1:0] CLASS_CRITICAL = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_LOW      = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_NORMAL   = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_FULL     = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BOTTOM_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_WRAPPED     = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_TOP      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EMPTY    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FULL     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CRITICAL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LOW      = 3'd5;

  localparam logic [OHM_W-1:0] RESET_TOP      = 24'd100000;
  localparam logic [OHM_W-1:0] RESET_BOTTOM   = 24'd100000;
  localparam logic [MV_W-1:0]  RESET_EMPTY    = 16'd3300;
  localparam logic [MV_W-1:0]  RESET_FULL     = 16'd4200;
  localparam logic [MV_W-1:0]  RESET_CRITICAL = 16'd3400;
  localparam logic [MV_W-1:0]  RESET_LOW      = 16'd3600;

  typedef struct packed {
    logic [OHM_W-1:0] top;
    logic [OHM_W-1:0] bottom;
    logic [MV_W-1:0]  empty;
    logic [MV_W-1:0]  full;
    logic [MV_W-1:0]  critical;
    logic [MV_W-1:0]  low;
  } blc_cfg_t;

  // One queued transaction as the front end leaves it for the back end.
  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             bottom_zero;
    logic [NUM_W-1:0] num;
  } blc_entry_t;

endpackage
`default_nettype wire

### rtl/blc_divider.sv
// Iterative restoring divider that retires STEP_BITS quotient bits per cycle.
`default_nettype none
module blc_divider #(
  parameter int DEN_W     = 24,
  parameter int QUO_W     = 39,
  parameter int STEP_BITS = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] num_hi,
  input  wire logic [QUO_W-1:0] num_lo,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);

  localparam int CYCLES = QUO_W / STEP_BITS;
  localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(CYCLES - 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] sh;
  logic [DEN_W-1:0] rem_next;
  logic [QUO_W-1:0] sh_next;
  logic [DEN_W:0]   trial;

  // The partial remainder stays below den, so one extra bit covers the shift.
  always_comb begin
    rem_next = rem;
    sh_next  = sh;
    trial    = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial   = {rem_next, sh_next[QUO_W-1]};
      sh_next = {sh_next[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next   = DEN_W'(trial - {1'b0, den});
        sh_next[0] = 1'b1;
      end else begin
        rem_next = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
      end else if (active) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_hi;
      sh  <= num_lo;
    end else if (active) begin
      rem <= rem_next;
      sh  <= sh_next;
    end
  end

  assign quo = sh;

endmodule
`default_nettype wire

### rtl/blc_front.sv
// Front end: takes a reading, forms the divider numerator and flags a zero bottom resistor.
`default_nettype none
module blc_front (
  input  wire logic                     start,
  input  wire logic [blc_pkg::PIN_W-1:0] pin_mv,
  input  wire logic [blc_pkg::OHM_W-1:0] top,
  input  wire logic [blc_pkg::OHM_W-1:0] bottom,
  input  wire logic                     q_full,
  output logic                          busy,
  output logic                          push,
  output blc_pkg::blc_entry_t           push_data
);

  logic [blc_pkg::OHM_W:0] ratio_sum;

  assign ratio_sum = {1'b0, top} + {1'b0, bottom};

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_data.pin         = pin_mv;
    push_data.bottom_zero = (bottom == '0);
    push_data.num         = blc_pkg::NUM_W'(pin_mv) * blc_pkg::NUM_W'(ratio_sum);
  end

endmodule
`default_nettype wire

### rtl/blc_queue.sv
// Small FIFO that decouples the front end from the back end.
`default_nettype none
module blc_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  blc_pkg::blc_entry_t push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output blc_pkg::blc_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  blc_pkg::blc_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_FULL);
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### rtl/blc_back.sv
// Back end: voltage division, percent division, classification and the result register.
`default_nettype none
module blc_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  blc_pkg::blc_cfg_t                  cfg,
  input  wire logic                          q_valid,
  input  blc_pkg::blc_entry_t                q_head,
  output logic                               q_pop,
  output logic                               done,
  output logic [blc_pkg::PIN_W-1:0]          pin_mv_echo,
  output logic [blc_pkg::MV_W-1:0]           battery_mv,
  output logic [blc_pkg::PCT_W-1:0]          charge_percent,
  output logic [blc_pkg::CLASS_W-1:0]        level_class,
  output logic [blc_pkg::STATUS_W-1:0]       status
);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_DIV  = 3'b010,
    A_WAIT = 3'b100
  } a_state_t;

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_MUL   = 4'b0010,
    B_START = 4'b0100,
    B_DIV   = 4'b1000
  } b_state_t;

  a_state_t a_state, a_state_next;
  b_state_t b_state, b_state_next;

  logic [blc_pkg::PIN_W-1:0]     a_pin;
  logic                          a_zero;
  logic                          quo_start;
  logic                          quo_done;
  logic [blc_pkg::QUO_W-1:0]     quo;

  logic [blc_pkg::PIN_W-1:0]     b_pin;
  logic                          b_zero;
  logic                          b_wrapped;
  logic [blc_pkg::MV_W-1:0]      b_v;
  logic [blc_pkg::PROD_W-1:0]    b_prod;
  logic [blc_pkg::PROD_W-1:0]    prod_w;
  logic [blc_pkg::MV_W-1:0]      span;
  logic                          pct_start;
  logic                          pct_done;
  logic [blc_pkg::PCT_QUO_W-1:0] pct_quo;

  logic                          handoff;
  logic                          below;
  logic                          above;
  logic                          out_load;
  logic [blc_pkg::PCT_W-1:0]     pct_w;
  logic [blc_pkg::CLASS_W-1:0]   class_w;
  logic [blc_pkg::STATUS_W-1:0]  status_w;

  // Voltage stage: one quotient at a time through the wide divider.
  assign q_pop     = (a_state == A_IDLE) && q_valid;
  assign quo_start = q_pop && !q_head.bottom_zero;
  assign handoff   = (a_state == A_WAIT) && (b_state == B_IDLE);

  blc_divider #(
    .DEN_W    (blc_pkg::OHM_W),
    .QUO_W    (blc_pkg::QUO_W),
    .STEP_BITS(blc_pkg::STEP_BITS)
  ) u_quo_div (
    .clk   (clk),
    .rst   (rst),
    .start (quo_start),
    .num_hi(blc_pkg::OHM_W'(0)),
    .num_lo(blc_pkg::QUO_W'(q_head.num)),
    .den   (cfg.bottom),
    .done  (quo_done),
    .quo   (quo)
  );

  always_comb begin
    a_state_next = a_state;
    unique case (a_state)
      A_IDLE: begin
        if (q_valid) begin
          a_state_next = q_head.bottom_zero ? A_WAIT : A_DIV;
        end
      end
      A_DIV: begin
        if (quo_done) begin
          a_state_next = A_WAIT;
        end
      end
      A_WAIT: begin
        if (b_state == B_IDLE) begin
          a_state_next = A_IDLE;
        end
      end
      default: a_state_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_state <= A_IDLE;
    end else begin
      a_state <= a_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_pin  <= q_head.pin;
      a_zero <= q_head.bottom_zero;
    end
  end

  // Percent stage: clamp tests, then (v - empty) * 100 / (full - empty) when in range.
  assign below  = (b_v <= cfg.empty);
  assign above  = (b_v >= cfg.full);
  assign span   = cfg.full - cfg.empty;
  assign prod_w = blc_pkg::PROD_W'(b_v - cfg.empty) * blc_pkg::PROD_W'(blc_pkg::PERCENT_FULL);
  assign pct_start = (b_state == B_START);

  blc_divider #(
    .DEN_W    (blc_pkg::MV_W),
    .QUO_W    (blc_pkg::PCT_QUO_W),
    .STEP_BITS(blc_pkg::STEP_BITS)
  ) u_pct_div (
    .clk   (clk),
    .rst   (rst),
    .start (pct_start),
    .num_hi(blc_pkg::MV_W'(b_prod[blc_pkg::PROD_W-1:blc_pkg::PCT_QUO_W])),
    .num_lo(b_prod[blc_pkg::PCT_QUO_W-1:0]),
    .den   (span),
    .done  (pct_done),
    .quo   (pct_quo)
  );

  assign out_load = ((b_state == B_MUL) && (b_zero || below || above)) ||
                    ((b_state == B_DIV) && pct_done);

  always_comb begin
    b_state_next = b_state;
    unique case (b_state)
      B_IDLE: begin
        if (handoff) begin
          b_state_next = B_MUL;
        end
      end
      B_MUL: begin
        b_state_next = (b_zero || below || above) ? B_IDLE : B_START;
      end
      B_START: b_state_next = B_DIV;
      B_DIV: begin
        if (pct_done) begin
          b_state_next = B_IDLE;
        end
      end
      default: b_state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_state <= B_IDLE;
    end else begin
      b_state <= b_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      b_pin     <= a_pin;
      b_zero    <= a_zero;
      b_wrapped <= (quo[blc_pkg::QUO_W-1:blc_pkg::MV_W] != '0);
      b_v       <= quo[blc_pkg::MV_W-1:0];
    end
    if (b_state == B_MUL) begin
      b_prod <= prod_w;
    end
  end

  // Class tests run in priority order: critical, low, full, then normal.
  always_comb begin
    if (b_zero) begin
      class_w = blc_pkg::CLASS_CRITICAL;
    end else if (b_v <= cfg.critical) begin
      class_w = blc_pkg::CLASS_CRITICAL;
    end else if (b_v <= cfg.low) begin
      class_w = blc_pkg::CLASS_LOW;
    end else if (above) begin
      class_w = blc_pkg::CLASS_FULL;
    end else begin
      class_w = blc_pkg::CLASS_NORMAL;
    end

    if (b_zero || below) begin
      pct_w = '0;
    end else if (above) begin
      pct_w = blc_pkg::PERCENT_FULL;
    end else begin
      pct_w = pct_quo[blc_pkg::PCT_W-1:0];
    end

    if (b_zero) begin
      status_w = blc_pkg::STATUS_BOTTOM_ZERO;
    end else if (b_wrapped) begin
      status_w = blc_pkg::STATUS_WRAPPED;
    end else begin
      status_w = blc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pin_mv_echo    <= b_pin;
      battery_mv     <= b_zero ? '0 : b_v;
      charge_percent <= pct_w;
      level_class    <= class_w;
      status         <= status_w;
    end
  end

endmodule
`default_nettype wire

### rtl/battery_level_classifier.sv
// A reading passes the queue, the voltage divider (skipped with a zero bottom resistor),
// handoff, clamp tests, the percent divider (only if the voltage lies strictly between the
// empty and full levels) and the result register. Results cannot be stalled; each is shown
// for exactly one cycle. Readings, paced by the voltage divider's 13 steps (3 quotient bits
// each), its done strobe, pop and handoff, overlap the percent stage; busy rises only when
// the queue is full. Reset: the registers return to their defaults, the queue and both divider stages empty out.
`default_nettype none
`include "assert_macros.svh"
module battery_level_classifier #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [blc_pkg::PIN_W-1:0]        pin_mv,
  output logic                                  done,
  output logic [blc_pkg::PIN_W-1:0]             pin_mv_echo,
  output logic [blc_pkg::MV_W-1:0]              battery_mv,
  output logic [blc_pkg::PCT_W-1:0]             charge_percent,
  output logic [blc_pkg::CLASS_W-1:0]           level_class,
  output logic [blc_pkg::STATUS_W-1:0]          status,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [blc_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [blc_pkg::DATA_W-1:0]       pwdata,
  output logic [blc_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready
);

  blc_pkg::blc_cfg_t   cfg;
  blc_pkg::blc_entry_t push_data;
  blc_pkg::blc_entry_t q_head;
  logic                push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  logic                cfg_write;
  logic [blc_pkg::REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[blc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.top      <= blc_pkg::RESET_TOP;
      cfg.bottom   <= blc_pkg::RESET_BOTTOM;
      cfg.empty    <= blc_pkg::RESET_EMPTY;
      cfg.full     <= blc_pkg::RESET_FULL;
      cfg.critical <= blc_pkg::RESET_CRITICAL;
      cfg.low      <= blc_pkg::RESET_LOW;
    end else if (cfg_write) begin
      unique case (reg_idx)
        blc_pkg::REG_TOP:      cfg.top      <= pwdata[blc_pkg::OHM_W-1:0];
        blc_pkg::REG_BOTTOM:   cfg.bottom   <= pwdata[blc_pkg::OHM_W-1:0];
        blc_pkg::REG_EMPTY:    cfg.empty    <= pwdata[blc_pkg::MV_W-1:0];
        blc_pkg::REG_FULL:     cfg.full     <= pwdata[blc_pkg::MV_W-1:0];
        blc_pkg::REG_CRITICAL: cfg.critical <= pwdata[blc_pkg::MV_W-1:0];
        blc_pkg::REG_LOW:      cfg.low      <= pwdata[blc_pkg::MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      blc_pkg::REG_TOP:      prdata = blc_pkg::DATA_W'(cfg.top);
      blc_pkg::REG_BOTTOM:   prdata = blc_pkg::DATA_W'(cfg.bottom);
      blc_pkg::REG_EMPTY:    prdata = blc_pkg::DATA_W'(cfg.empty);
      blc_pkg::REG_FULL:     prdata = blc_pkg::DATA_W'(cfg.full);
      blc_pkg::REG_CRITICAL: prdata = blc_pkg::DATA_W'(cfg.critical);
      blc_pkg::REG_LOW:      prdata = blc_pkg::DATA_W'(cfg.low);
      default:               prdata = '0;
    endcase
  end

  blc_front u_front (
    .start    (start),
    .pin_mv   (pin_mv),
    .top      (cfg.top),
    .bottom   (cfg.bottom),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_data(push_data)
  );

  blc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  blc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .done          (done),
    .pin_mv_echo   (pin_mv_echo),
    .battery_mv    (battery_mv),
    .charge_percent(charge_percent),
    .level_class   (level_class),
    .status        (status)
  );

  // Results of successive transactions can never land on adjacent cycles.
  `ASSERT_NEXT(a_strobe_single, clk, rst, done, !done)
  // An accepted transaction is always visible in the queue on the next cycle.
  `ASSERT_NEXT(a_push_lands, clk, rst, start && !busy, q_valid)
  `ASSERT_IMPLIES(a_percent_range, clk, rst, done, charge_percent <= blc_pkg::PERCENT_FULL)

endmodule
`default_nettype wire
